FILE: hw/rtl/bps_pkg.sv
// Shared constants and register codes of the Blinn-Phong shader.
package bps_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int Q30 = 30;
  localparam int SHINE_W = 12;
  localparam int ROOT_PASSES = 4;
  localparam int POW_BW = Q30 + 1;

  typedef enum logic [2:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_LIGHT_RGB = 3'd3,
    REG_DIFFUSE   = 3'd4,
    REG_SPECULAR  = 3'd5,
    REG_SHINE     = 3'd6
  } reg_idx_t;

endpackage

FILE: hw/rtl/bps_channels.sv
// Stream interfaces for the fragment input and the color output.
interface bps_frag_if #(parameter int DW = 16) ();
  logic valid;
  logic ready;
  logic signed [DW-1:0] normal_x;
  logic signed [DW-1:0] normal_y;
  logic signed [DW-1:0] normal_z;
  logic signed [DW-1:0] view_x;
  logic signed [DW-1:0] view_y;
  logic signed [DW-1:0] view_z;
  modport source (output valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, view_x, view_y, view_z,
                output ready);
endinterface

interface bps_rgb_if #(parameter int CB = 8) ();
  logic valid;
  logic ready;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: hw/rtl/blinn_phong_shader.sv
// Blinn-Phong shader top level: registers, dot products, divider, power and color stages.
//
//   channel | dir | words                          | handshake
//   frag    | in  | normal_x..z, view_x..z         | valid/ready
//   rgb     | out | red, green, blue               | valid/ready
//   apb     | in  | seven light/material registers | psel/penable, pready high
//
// One word per cycle while the skid slot is empty.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// The whole pipeline advances while the skid slot behind the output register is empty,
// so one finished word may wait without blocking intake; a stall holds every stage.
module blinn_phong_shader
  import bps_pkg::*;
#(
  parameter int DIR_WIDTH  = 16,
  parameter int COLOR_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  bps_frag_if.sink          frag,
  bps_rgb_if.source         rgb
);

  localparam int DW    = DIR_WIDTH;
  localparam int CB    = COLOR_BITS;
  localparam int F     = DW - 2;
  localparam int LW    = DW - 1;
  localparam int PLW   = 2 * DW;
  localparam int PHW   = 2 * DW + 1;
  localparam int PQW   = 2 * DW + 2;
  localparam int DLW   = 2 * DW + 2;
  localparam int DHW   = 2 * DW + 3;
  localparam int QW    = 2 * DW + 14;
  localparam int RW    = QW / 2;
  localparam int NW    = 2 * DW + 8;
  localparam int BW    = POW_BW;
  localparam int RTW   = 2 * BW;
  localparam int TW    = CB + 31;
  localparam int UW    = 2 * CB + 1;
  localparam int CW    = 3 * CB;
  localparam int CMAX  = (1 << CB) - 1;
  localparam logic [LW-1:0] ONE = LW'(1) << F;

  // Registers.
  logic signed [DW-1:0] light_x, light_y, light_z;
  logic [CW-1:0]        light_rgb, diffuse_rgb, specular_rgb;
  logic [SHINE_W-1:0]   shininess;
  logic                 wr;
  reg_idx_t             widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x      <= '0;
      light_y      <= DW'(1) << F;
      light_z      <= '0;
      light_rgb    <= '1;
      diffuse_rgb  <= {3{CB'(1) << (CB - 1)}};
      specular_rgb <= '1;
      shininess    <= SHINE_W'(512);
    end else if (wr) begin
      unique case (widx)
        REG_LIGHT_X:   light_x      <= pwdata[DW-1:0];
        REG_LIGHT_Y:   light_y      <= pwdata[DW-1:0];
        REG_LIGHT_Z:   light_z      <= pwdata[DW-1:0];
        REG_LIGHT_RGB: light_rgb    <= pwdata[CW-1:0];
        REG_DIFFUSE:   diffuse_rgb  <= pwdata[CW-1:0];
        REG_SPECULAR:  specular_rgb <= pwdata[CW-1:0];
        REG_SHINE:     shininess    <= pwdata[SHINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_LIGHT_X:   prdata = DATA_W'($unsigned(light_x));
      REG_LIGHT_Y:   prdata = DATA_W'($unsigned(light_y));
      REG_LIGHT_Z:   prdata = DATA_W'($unsigned(light_z));
      REG_LIGHT_RGB: prdata = DATA_W'(light_rgb);
      REG_DIFFUSE:   prdata = DATA_W'(diffuse_rgb);
      REG_SPECULAR:  prdata = DATA_W'(specular_rgb);
      REG_SHINE:     prdata = DATA_W'(shininess);
      default:       prdata = '0;
    endcase
  end

  // Flow control.
  logic en;
  logic out_valid, skid_valid;
  assign en         = !skid_valid;
  assign frag.ready = en;

  // Stage A: products.
  logic signed [DW-1:0] nv [3];
  logic signed [DW-1:0] lv [3];
  logic signed [DW-1:0] vv [3];
  logic signed [DW:0]   hv [3];
  logic signed [PLW-1:0] a_pl [3];
  logic signed [PHW-1:0] a_ph [3];
  logic signed [PQW-1:0] a_pq [3];
  logic                  a_v;

  assign nv[0] = frag.normal_x;
  assign nv[1] = frag.normal_y;
  assign nv[2] = frag.normal_z;
  assign vv[0] = frag.view_x;
  assign vv[1] = frag.view_y;
  assign vv[2] = frag.view_z;
  assign lv[0] = light_x;
  assign lv[1] = light_y;
  assign lv[2] = light_z;

  for (genvar i = 0; i < 3; i++) begin : g_half
    assign hv[i] = (DW+1)'(lv[i]) - (DW+1)'(vv[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= frag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_pl[i] <= PLW'(nv[i]) * PLW'(lv[i]);
        a_ph[i] <= PHW'(nv[i]) * PHW'(hv[i]);
        a_pq[i] <= PQW'(hv[i]) * PQW'(hv[i]);
      end
    end
  end

  // Stage B: sums, clamp of N.L, numerator of N.H.
  logic signed [DLW-1:0] dl, dl_sh;
  logic signed [DHW-1:0] dh;
  logic [PQW-1:0]        qsum;
  logic [LW-1:0]         b_ndl;
  logic [NW-1:0]         b_num;
  logic                  b_spec;
  logic [QW-1:0]         b_qs;
  logic                  b_v;

  assign dl    = DLW'(a_pl[0]) + DLW'(a_pl[1]) + DLW'(a_pl[2]);
  assign dh    = DHW'(a_ph[0]) + DHW'(a_ph[1]) + DHW'(a_ph[2]);
  assign qsum  = $unsigned(a_pq[0]) + $unsigned(a_pq[1]) + $unsigned(a_pq[2]);
  assign dl_sh = dl >>> F;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dl <= 0) begin
        b_ndl <= '0;
      end else if (dl_sh > DLW'(ONE)) begin
        b_ndl <= ONE;
      end else begin
        b_ndl <= dl_sh[LW-1:0];
      end
      b_num  <= (dh > 0) ? (NW'($unsigned(dh)) << 6) : '0;
      b_spec <= (dh > 0) && (qsum != '0);
      b_qs   <= {qsum, 12'b0};
    end
  end

  // Length of the half vector.
  logic          r1_v;
  logic [RW-1:0] r1_root;
  logic [NW+LW:0] r1_side;

  bps_isqrt #(.W(QW), .SW(NW + LW + 1)) u_len (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_v),
    .radicand  (b_qs),
    .in_side   ({b_num, b_spec, b_ndl}),
    .out_valid (r1_v),
    .root      (r1_root),
    .out_side  (r1_side)
  );

  // Divider: N.H = numerator / length, saturating at 1.0.
  logic [NW-1:0] dv_rem  [DW+1];
  logic [RW-1:0] dv_r    [DW+1];
  logic [DW-1:0] dv_quo  [DW+1];
  logic          dv_sat  [DW+1];
  logic          dv_spec [DW+1];
  logic [LW-1:0] dv_ndl  [DW+1];
  logic          dv_v    [DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= r1_side[NW+LW:LW+1];
      dv_r[0]    <= r1_root;
      dv_quo[0]  <= '0;
      dv_sat[0]  <= r1_side[NW+LW:LW+1] >= (NW'(r1_root) << DW);
      dv_spec[0] <= r1_side[LW];
      dv_ndl[0]  <= r1_side[LW-1:0];
    end
  end

  for (genvar g = 1; g <= DW; g++) begin : g_div
    localparam int K = DW - g;
    logic [NW-1:0] dsub;
    logic          take;
    assign dsub = NW'(dv_r[g-1]) << K;
    assign take = !dv_sat[g-1] && (dv_rem[g-1] >= dsub);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g] <= 1'b0;
      end else if (en) begin
        dv_v[g] <= dv_v[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[g]  <= take ? dv_rem[g-1] - dsub : dv_rem[g-1];
        dv_r[g]    <= dv_r[g-1];
        dv_quo[g]  <= dv_quo[g-1] | (DW'(take) << K);
        dv_sat[g]  <= dv_sat[g-1];
        dv_spec[g] <= dv_spec[g-1];
        dv_ndl[g]  <= dv_ndl[g-1];
      end
    end
  end

  logic [DW-1:0] ndh;
  logic [BW-1:0] nd_base;
  logic [LW-1:0] nd_ndl;
  logic          nd_v;

  always_comb begin
    if (!dv_spec[DW]) begin
      ndh = '0;
    end else if (dv_sat[DW] || (dv_quo[DW] > DW'(ONE))) begin
      ndh = DW'(ONE);
    end else begin
      ndh = dv_quo[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nd_v <= 1'b0;
    end else if (en) begin
      nd_v <= dv_v[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nd_base <= BW'(ndh) << (Q30 - F);
      nd_ndl  <= dv_ndl[DW];
    end
  end

  // Four square roots give the sixteenth root of N.H for the Q8.4 exponent.
  logic [BW-1:0] rt_base [ROOT_PASSES+1];
  logic [LW-1:0] rt_ndl  [ROOT_PASSES+1];
  logic          rt_v    [ROOT_PASSES+1];

  assign rt_base[0] = nd_base;
  assign rt_ndl[0]  = nd_ndl;
  assign rt_v[0]    = nd_v;

  for (genvar r = 0; r < ROOT_PASSES; r++) begin : g_root
    bps_isqrt #(.W(RTW), .SW(LW)) u_root (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (rt_v[r]),
      .radicand  ({1'b0, rt_base[r], {Q30{1'b0}}}),
      .in_side   (rt_ndl[r]),
      .out_valid (rt_v[r+1]),
      .root      (rt_base[r+1]),
      .out_side  (rt_ndl[r+1])
    );
  end

  // Square and multiply over the exponent bits, lowest first.
  logic [BW-1:0] pw_acc  [SHINE_W];
  logic [BW-1:0] pw_base [SHINE_W];
  logic [LW-1:0] pw_ndl  [SHINE_W];
  logic          pw_v    [SHINE_W];

  for (genvar g = 0; g < SHINE_W; g++) begin : g_pow
    logic [BW-1:0]  src_acc, src_base;
    logic [LW-1:0]  src_ndl;
    logic           src_v;
    logic [RTW-1:0] p_ab, p_bb;

    if (g == 0) begin : g_first
      assign src_acc  = BW'(1) << Q30;
      assign src_base = rt_base[ROOT_PASSES];
      assign src_ndl  = rt_ndl[ROOT_PASSES];
      assign src_v    = rt_v[ROOT_PASSES];
    end else begin : g_next
      assign src_acc  = pw_acc[g-1];
      assign src_base = pw_base[g-1];
      assign src_ndl  = pw_ndl[g-1];
      assign src_v    = pw_v[g-1];
    end

    assign p_ab = RTW'(src_acc) * RTW'(src_base);
    assign p_bb = RTW'(src_base) * RTW'(src_base);

    always_ff @(posedge clk) begin
      if (rst) begin
        pw_v[g] <= 1'b0;
      end else if (en) begin
        pw_v[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pw_acc[g]  <= shininess[g] ? p_ab[Q30 +: BW] : src_acc;
        pw_base[g] <= p_bb[Q30 +: BW];
        pw_ndl[g]  <= src_ndl;
      end
    end
  end

  // Color stages.
  logic [BW-1:0]      ndl_q;
  logic [TW-1:0]      c1_t [3];
  logic               c1_v;
  logic [TW+CB-1:0]   c2_prod [3];
  logic [UW-1:0]      c2_u [3];
  logic               c2_v;
  logic [2*CB-1:0]    c3_u [3];
  logic [CB:0]        c3_q0 [3];
  logic               c3_sat [3];
  logic               c3_v;

  assign ndl_q = BW'(pw_ndl[SHINE_W-1]) << (Q30 - F);

  for (genvar i = 0; i < 3; i++) begin : g_prod
    assign c2_prod[i] = (TW+CB)'(c1_t[i]) * (TW+CB)'(light_rgb[(2-i)*CB +: CB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
    end else if (en) begin
      c1_v <= pw_v[SHINE_W-1];
      c2_v <= c1_v;
      c3_v <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c1_t[i]   <= TW'(diffuse_rgb[(2-i)*CB +: CB]) * TW'(ndl_q)
                   + TW'(specular_rgb[(2-i)*CB +: CB]) * TW'(pw_acc[SHINE_W-1]);
        c2_u[i]   <= c2_prod[i][Q30 +: UW];
        c3_sat[i] <= c2_u[i] >= UW'(CMAX * (CMAX + 1));
        c3_u[i]   <= c2_u[i][2*CB-1:0];
        c3_q0[i]  <= (CB+1)'((UW'(c2_u[i][2*CB-1:0]) + UW'(c2_u[i][2*CB-1:CB])) >> CB);
      end
    end
  end

  logic [CB-1:0] chan [3];
  for (genvar i = 0; i < 3; i++) begin : g_fix
    logic [UW-1:0] rr;
    logic [CB:0]   qc;
    assign rr = UW'(c3_u[i]) - UW'(c3_q0[i]) * UW'(CMAX);
    assign qc = (rr >= UW'(CMAX)) ? c3_q0[i] + 1'b1 : c3_q0[i];
    assign chan[i] = c3_sat[i] ? CB'(CMAX) : qc[CB-1:0];
  end

  // Output register and skid slot.
  logic [CB-1:0] out_red, out_green, out_blue;
  logic [CB-1:0] skid_red, skid_green, skid_blue;
  logic          pop, push;

  assign pop  = out_valid && rgb.ready;
  assign push = en && c3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_red   <= skid_red;
        out_green <= skid_green;
        out_blue  <= skid_blue;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_red   <= chan[0];
        out_green <= chan[1];
        out_blue  <= chan[2];
      end else begin
        skid_red   <= chan[0];
        skid_green <= chan[1];
        skid_blue  <= chan[2];
      end
    end
  end

  assign rgb.valid = out_valid;
  assign rgb.red   = out_red;
  assign rgb.green = out_green;
  assign rgb.blue  = out_blue;

endmodule

FILE: hw/rtl/bps_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband word.
module bps_isqrt #(
  parameter int W  = 62,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  radicand,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W/2-1:0] root,
  output logic [SW-1:0] out_side
);

  localparam int K = W / 2;

  logic [W-1:0]  rem_q  [K];
  logic [W-1:0]  res_q  [K];
  logic          vld_q  [K];
  logic [SW-1:0] side_q [K];

  for (genvar g = 0; g < K; g++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (K - 1 - g));
    logic [W-1:0]  src_rem;
    logic [W-1:0]  src_res;
    logic [W-1:0]  trial;
    logic          src_v;
    logic [SW-1:0] src_side;

    if (g == 0) begin : g_first
      assign src_rem  = radicand;
      assign src_res  = '0;
      assign src_v    = in_valid;
      assign src_side = in_side;
    end else begin : g_next
      assign src_rem  = rem_q[g-1];
      assign src_res  = res_q[g-1];
      assign src_v    = vld_q[g-1];
      assign src_side = side_q[g-1];
    end

    assign trial = src_res + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[g] <= src_side;
        if (src_rem >= trial) begin
          rem_q[g] <= src_rem - trial;
          res_q[g] <= (src_res >> 1) + BIT;
        end else begin
          rem_q[g] <= src_rem;
          res_q[g] <= src_res >> 1;
        end
      end
    end
  end

  assign out_valid = vld_q[K-1];
  assign root      = res_q[K-1][K-1:0];
  assign out_side  = side_q[K-1];

endmodule

FILE: hw/rtl/bps_checker.sv
// Port-level assertions for the Blinn-Phong shader and their bind.
module bps_assertions
  import bps_pkg::*;
#(
  parameter int CB = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] prdata,
  input logic              frag_ready,
  input logic              rgb_valid,
  input logic              rgb_ready,
  input logic [CB-1:0]     rgb_red,
  input logic [CB-1:0]     rgb_green,
  input logic [CB-1:0]     rgb_blue
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb_red) && $stable(rgb_green)
      && $stable(rgb_blue))
    else $error("stalled color word changed");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rgb_valid)
    else $error("color word valid right after reset");

  a_intake: assert property (@(posedge clk) disable iff (rst) !rgb_valid |-> frag_ready)
    else $error("intake blocked with empty output");

  a_shine_read: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && paddr == {REG_SHINE, 2'b00} |-> prdata[DATA_W-1:SHINE_W] == '0)
    else $error("shininess readback has stray bits");

endmodule

bind blinn_phong_shader bps_assertions #(.CB(COLOR_BITS)) u_bps_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .prdata     (prdata),
  .frag_ready (frag.ready),
  .rgb_valid  (rgb.valid),
  .rgb_ready  (rgb.ready),
  .rgb_red    (rgb.red),
  .rgb_green  (rgb.green),
  .rgb_blue   (rgb.blue)
);

FILE: verif/bps_checker.sv
// Shading predictor and color scoreboard for the Blinn-Phong shader.
`timescale 1ns / 100ps
module bps_checker
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic        pready,
  bps_frag_if         frag,
  bps_rgb_if          rgb,
  output int          errors,
  output int          pending
);

  localparam int FR = 14;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic signed [15:0] lx, ly, lz;
  logic [23:0] light_c, diff_c, spec_c;
  logic [11:0] shine;
  color_t color_q[$];

  assign pending = color_q.size();

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned spec_power(longint unsigned x, logic [11:0] s);
    longint unsigned base, acc;
    acc = 64'd1 << 30;
    if (s == 0) return acc;
    base = x << (30 - FR);
    for (int i = 0; i < 4; i++) base = root64(base << 30);
    while (s != 0) begin
      if (s[0]) acc = (acc * base) >> 30;
      base = (base * base) >> 30;
      s >>= 1;
    end
    return acc;
  endfunction

  function automatic color_t shade(logic signed [15:0] nx, ny, nz, vx, vy, vz);
    longint n[3], l[3], h[3];
    longint dl, dh;
    longint unsigned q, ndl, ndh, p, t, v;
    logic [7:0] ch[3];
    color_t c;
    n = '{longint'(nx), longint'(ny), longint'(nz)};
    l = '{longint'(lx), longint'(ly), longint'(lz)};
    h = '{l[0] - longint'(vx), l[1] - longint'(vy), l[2] - longint'(vz)};
    dl = 0; dh = 0; q = 0; ndl = 0; ndh = 0;
    for (int i = 0; i < 3; i++) begin
      dl += n[i] * l[i];
      dh += n[i] * h[i];
      q += longint'(h[i] * h[i]);
    end
    if (dl > 0) begin
      ndl = longint'(dl) >> FR;
      if (ndl > (1 << FR)) ndl = 1 << FR;
    end
    if (dh > 0 && q != 0) begin
      ndh = (longint'(dh) * 64) / root64(q << 12);
      if (ndh > (1 << FR)) ndh = 1 << FR;
    end
    p = spec_power(ndh, shine);
    for (int i = 0; i < 3; i++) begin
      t = diff_c[(2-i)*8 +: 8] * (ndl << (30 - FR)) + spec_c[(2-i)*8 +: 8] * p;
      v = (t * light_c[(2-i)*8 +: 8]) / (64'd255 << 30);
      ch[i] = (v > 255) ? 8'd255 : v[7:0];
    end
    c.red = ch[0];
    c.green = ch[1];
    c.blue = ch[2];
    return c;
  endfunction

  always @(posedge clk) begin
    color_t got, want;
    if (rst) begin
      lx <= 16'sd0;
      ly <= 16'sd16384;
      lz <= 16'sd0;
      light_c <= 24'hffffff;
      diff_c <= 24'h808080;
      spec_c <= 24'hffffff;
      shine <= 12'd512;
      errors <= 0;
      color_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_LIGHT_X:   lx <= pwdata[15:0];
          REG_LIGHT_Y:   ly <= pwdata[15:0];
          REG_LIGHT_Z:   lz <= pwdata[15:0];
          REG_LIGHT_RGB: light_c <= pwdata[23:0];
          REG_DIFFUSE:   diff_c <= pwdata[23:0];
          REG_SPECULAR:  spec_c <= pwdata[23:0];
          REG_SHINE:     shine <= pwdata[11:0];
          default: ;
        endcase
      end
      if (frag.valid && frag.ready)
        color_q.push_back(shade(frag.normal_x, frag.normal_y, frag.normal_z,
                                frag.view_x, frag.view_y, frag.view_z));
      if (rgb.valid && rgb.ready) begin
        got = '{rgb.red, rgb.green, rgb.blue};
        if (color_q.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = color_q.pop_front();
          if (got != want) begin
            $display("%0t: color mismatch, expected %h actual %h", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// Stimulus and verdict for the Blinn-Phong shader.
`timescale 1ns / 100ps
module testbench;
  import bps_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  int errors, pending;
  int idle_pct = 0, stall_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  bps_frag_if #(16) frag ();
  bps_rgb_if #(8) rgb ();

  blinn_phong_shader u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .frag(frag.sink), .rgb(rgb.source)
  );

  bps_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .frag(frag), .rgb(rgb), .errors, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    frag.valid = 1'b0;
    {frag.normal_x, frag.normal_y, frag.normal_z} = '0;
    {frag.view_x, frag.view_y, frag.view_z} = '0;
    rgb.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      rgb.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      rgb.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'(int'($urandom_range(65535)));
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic send(logic [15:0] nx, ny, nz, vx, vy, vz);
    while ($urandom_range(99) < idle_pct) begin
      frag.valid <= 1'b0;
      @(posedge clk);
    end
    frag.valid <= 1'b1;
    frag.normal_x <= nx; frag.normal_y <= ny; frag.normal_z <= nz;
    frag.view_x <= vx; frag.view_y <= vy; frag.view_z <= vz;
    do @(posedge clk); while (!frag.ready);
  endtask

  task automatic send_rand();
    send(rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir());
  endtask

  task automatic drain();
    frag.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic setup(int sel);
    case (sel)
      0: begin
        reg_write(REG_LIGHT_X, 32'hffffc000); reg_write(REG_LIGHT_Y, 0);
        reg_write(REG_LIGHT_Z, 0); reg_write(REG_SHINE, 12'd0);
        reg_write(REG_LIGHT_RGB, 24'h000000); reg_write(REG_DIFFUSE, 24'hffffff);
        reg_write(REG_SPECULAR, 24'h000000);
      end
      1: begin
        reg_write(REG_LIGHT_X, 0); reg_write(REG_LIGHT_Y, 0);
        reg_write(REG_LIGHT_Z, 32'h4000); reg_write(REG_SHINE, 12'hfff);
        reg_write(REG_LIGHT_RGB, 24'hffffff); reg_write(REG_DIFFUSE, 24'hffffff);
        reg_write(REG_SPECULAR, 24'hffffff);
      end
      default: begin
        reg_write(REG_LIGHT_X, rand_dir()); reg_write(REG_LIGHT_Y, rand_dir());
        reg_write(REG_LIGHT_Z, rand_dir()); reg_write(REG_SHINE, $urandom_range(4095));
        reg_write(REG_LIGHT_RGB, $urandom_range(24'hffffff));
        reg_write(REG_DIFFUSE, $urandom_range(24'hffffff));
        reg_write(REG_SPECULAR, $urandom_range(24'hffffff));
      end
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed words at reset settings: axis extremes, zero half vector, overflow.
    send(0, 16'sd16384, 0, 0, -16'sd16384, 0);
    send(0, 16'sd16384, 0, 0, 16'sd16384, 0);
    send(0, -16'sd16384, 0, 0, -16'sd16384, 0);
    send(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send(0, 0, 0, 0, 0, 0);
    send(11585, 11585, 0, 0, -16384, 0);
    send(0, 16384, 0, 11585, -11585, 0);
    drain();
    setup(0);
    send(-16384, 0, 0, 16384, 0, 0);
    send(-16384, 0, 0, -16384, 0, 0);
    send(16384, 0, 0, 0, 0, 0);
    drain();
    setup(1);
    send(0, 0, 16384, 0, 0, -16384);
    send(0, 0, 16384, 0, 0, 16384);
    send(0, 11585, 11585, 0, 0, -16384);
    send(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 16'h8000);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      setup(ph < 2 ? ph : 2);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 65; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 65; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      if (ph == 4) hold_off = 400;
      for (int i = 0; i < 210; i++) send_rand();
      idle_pct = 0; stall_pct = 0;
      drain();
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
